@@ hdl/rsa_pkg.sv @@
// shared types and constants for the region statistics accumulator
package rsa_pkg;

   // item function codes
   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_PIXEL  = 2'd1,
      FUNC_EDGE   = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   localparam int COUNT_BITS = 21;
   localparam int SUM_BITS   = 36;
   localparam int SQ_BITS    = 50;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [SQ_BITS-1:0]    SQ_MAX    = {SQ_BITS{1'b1}};

   // sequencer states
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

endpackage

@@ hdl/region_statistics_accumulator_unit.sv @@
// top level of the region statistics accumulator
// Keeps per-label region statistics in two memories with registered reads (region
// and boundary). After reset a clearing pass writes every entry; no transaction
// is accepted until it ends. An update transaction is one memory read followed by
// one modify-write, and no new transaction is accepted until the write is done. A
// readout passes through ST_READ and ST_DIV and waits in ST_OUT until the result
// is taken; the bit-serial divider computes both means in parallel lanes over 37
// steps.
module region_statistics_accumulator_unit
   import rsa_pkg::*;
#(
   parameter int REGION_COUNT     = 256,
   parameter int PIXEL_INDEX_BITS = 20,
   parameter int VALUE_BITS       = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // func[1:0], region[9:2], pixel_index[29:10], value[45:30]
   input  logic [47:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // region_id[7:0], pixel_count[28:8], value_sum[65:29], square_sum[116:66],
   // min_value[132:117], min_location[152:133], max_value[168:153],
   // mean_value[184:169], edge_count[205:185], edge_min[221:206],
   // edge_mean[237:222], empty_flags[239:238]
   output logic [239:0] rsp_tdata
);

   localparam int ADDR_BITS = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
   localparam int ABITS     = SUM_BITS + 1;
   localparam int STEP_BITS = $clog2(ABITS + 1);
   localparam logic signed [SUM_BITS-1:0] SUM_HI = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_LO = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] VHI = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VLO = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef struct packed {
      logic [COUNT_BITS-1:0]        cnt;
      logic signed [SUM_BITS-1:0]   sum;
      logic [SQ_BITS-1:0]           sq;
      logic signed [VALUE_BITS-1:0] mn;
      logic [PIXEL_INDEX_BITS-1:0]  mloc;
      logic signed [VALUE_BITS-1:0] mx;
   } reg_rec_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]        cnt;
      logic signed [VALUE_BITS-1:0] mn;
      logic signed [SUM_BITS-1:0]   sum;
   } edge_rec_type;

   localparam reg_rec_type  REG_INIT  = '{cnt: '0, sum: '0, sq: '0, mn: VHI,
                                          mloc: '0, mx: VLO};
   localparam edge_rec_type EDGE_INIT = '{cnt: '0, mn: VHI, sum: '0};

   // memories
   reg_rec_type  reg_mem  [REGION_COUNT];
   edge_rec_type edge_mem [REGION_COUNT];
   reg_rec_type  reg_rd_ff;
   edge_rec_type edge_rd_ff;

   state_type state_ff, state_in;
   logic [ADDR_BITS:0] clr_ff, clr_in;
   logic bnd_en_ff;

   // captured transaction
   logic [1:0]                   func_ff;
   logic [7:0]                   region_ff;
   logic [PIXEL_INDEX_BITS-1:0]  pix_ff;
   logic signed [VALUE_BITS-1:0] val_ff;
   logic                         ok_ff;
   logic                         pend_ff, pend_in;

   logic [1:0]                   in_func;
   logic [7:0]                   in_region;
   logic                         in_ok;
   logic                         accept;

   assign in_func   = req_tdata[1:0];
   assign in_region = req_tdata[9:2];
   assign in_ok     = {24'd0, in_region} < 32'(REGION_COUNT);
   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !pend_ff;
   assign accept     = req_tvalid && req_tready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_en_ff <= 1'b1;
      end else if (csr_valid) begin
         bnd_en_ff <= csr_data;
      end
   end

   // capture transaction, low bits of the index and value fields
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= in_func;
         region_ff <= in_region;
         pix_ff    <= PIXEL_INDEX_BITS'({{PIXEL_INDEX_BITS{1'b0}}, req_tdata[29:10]});
         val_ff    <= VALUE_BITS'({{VALUE_BITS{1'b0}}, req_tdata[45:30]});
         ok_ff     <= in_ok;
      end
   end

   logic [ADDR_BITS-1:0] rd_addr, wr_addr;
   logic [ADDR_BITS-1:0] cur_addr;
   assign rd_addr  = ADDR_BITS'(in_region);
   assign cur_addr = ADDR_BITS'(region_ff);

   // read-modify-write of the pending transaction, and the writes of the clearing pass
   reg_rec_type  reg_new;
   edge_rec_type edge_new;
   logic reg_we, edge_we;
   logic signed [SUM_BITS:0]   sum_x, esum_x;
   logic [2*VALUE_BITS-1:0]    vsq;
   logic [SQ_BITS:0]           sq_x;

   always_comb begin
      vsq      = val_ff * val_ff;
      sum_x    = (SUM_BITS+1)'(reg_rd_ff.sum) + (SUM_BITS+1)'(val_ff);
      esum_x   = (SUM_BITS+1)'(edge_rd_ff.sum) + (SUM_BITS+1)'(val_ff);
      sq_x     = (SQ_BITS+1)'(reg_rd_ff.sq) + (SQ_BITS+1)'(vsq);
      reg_new  = reg_rd_ff;
      edge_new = edge_rd_ff;
      reg_we   = 1'b0;
      edge_we  = 1'b0;
      wr_addr  = cur_addr;
      if (state_ff == ST_CLEAR) begin
         reg_new  = REG_INIT;
         edge_new = EDGE_INIT;
         reg_we   = 1'b1;
         edge_we  = 1'b1;
         wr_addr  = clr_ff[ADDR_BITS-1:0];
      end else if (pend_ff && ok_ff) begin
         unique case (func_type'(func_ff))
            FUNC_CLEAR: begin
               reg_new  = REG_INIT;
               edge_new = EDGE_INIT;
               reg_we   = 1'b1;
               edge_we  = 1'b1;
            end
            FUNC_PIXEL: begin
               reg_we = 1'b1;
               if (reg_rd_ff.cnt == '0 || val_ff < reg_rd_ff.mn) begin
                  reg_new.mn   = val_ff;
                  reg_new.mloc = pix_ff;
               end
               if (val_ff > reg_rd_ff.mx) reg_new.mx = val_ff;
               if (reg_rd_ff.cnt != COUNT_MAX) reg_new.cnt = reg_rd_ff.cnt + 1'b1;
               if (sum_x > (SUM_BITS+1)'(SUM_HI)) reg_new.sum = SUM_HI;
               else if (sum_x < (SUM_BITS+1)'(SUM_LO)) reg_new.sum = SUM_LO;
               else reg_new.sum = SUM_BITS'(sum_x);
               reg_new.sq = sq_x[SQ_BITS] ? SQ_MAX : SQ_BITS'(sq_x);
            end
            FUNC_EDGE: begin
               edge_we = bnd_en_ff;
               if (edge_rd_ff.cnt == '0 || val_ff < edge_rd_ff.mn) edge_new.mn = val_ff;
               if (edge_rd_ff.cnt != COUNT_MAX) edge_new.cnt = edge_rd_ff.cnt + 1'b1;
               if (esum_x > (SUM_BITS+1)'(SUM_HI)) edge_new.sum = SUM_HI;
               else if (esum_x < (SUM_BITS+1)'(SUM_LO)) edge_new.sum = SUM_LO;
               else edge_new.sum = SUM_BITS'(esum_x);
            end
            FUNC_READ: begin
            end
            default: begin
            end
         endcase
      end
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (reg_we) reg_mem[wr_addr] <= reg_new;
      if (edge_we) edge_mem[wr_addr] <= edge_new;
      reg_rd_ff  <= reg_mem[rd_addr];
      edge_rd_ff <= edge_mem[rd_addr];
   end

   // divider lanes: region mean and boundary mean
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [ABITS-1:0]       q0_ff, q1_ff, q0_in, q1_in;
   logic [COUNT_BITS:0]    r0_ff, r1_ff, r0_in, r1_in;
   logic                   n0_ff, n1_ff;
   logic [COUNT_BITS:0]    t0, t1;
   reg_rec_type            hold_ff;
   edge_rec_type           ehold_ff;
   logic signed [ABITS:0]  m0, m1;
   logic signed [VALUE_BITS-1:0] mean0, mean1;

   function automatic logic [ABITS-1:0] mag(input logic signed [SUM_BITS-1:0] s);
      logic signed [ABITS-1:0] w;
      w = ABITS'(s);
      return w[ABITS-1] ? ABITS'(-w) : w;
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] clampv(
      input logic signed [ABITS:0] m);
      if (m > (ABITS+1)'(VHI)) return VHI;
      if (m < (ABITS+1)'(VLO)) return VLO;
      return VALUE_BITS'(m);
   endfunction

   always_comb begin
      t0 = {r0_ff[COUNT_BITS-1:0], q0_ff[ABITS-1]};
      t1 = {r1_ff[COUNT_BITS-1:0], q1_ff[ABITS-1]};
      q0_in = {q0_ff[ABITS-2:0], 1'b0};
      q1_in = {q1_ff[ABITS-2:0], 1'b0};
      r0_in = t0;
      r1_in = t1;
      if (t0 >= {1'b0, hold_ff.cnt}) begin
         r0_in = t0 - {1'b0, hold_ff.cnt};
         q0_in[0] = 1'b1;
      end
      if (t1 >= {1'b0, ehold_ff.cnt}) begin
         r1_in = t1 - {1'b0, ehold_ff.cnt};
         q1_in[0] = 1'b1;
      end
      m0 = n0_ff ? -$signed({2'b00, q0_ff[ABITS-2:0]}) : $signed({2'b00, q0_ff[ABITS-2:0]});
      m1 = n1_ff ? -$signed({2'b00, q1_ff[ABITS-2:0]}) : $signed({2'b00, q1_ff[ABITS-2:0]});
      mean0 = (hold_ff.cnt == '0) ? '0 : clampv(m0);
      mean1 = (ehold_ff.cnt == '0) ? '0 : clampv(m1);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      pend_in  = pend_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (ADDR_BITS+1)'(REGION_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pend_ff) begin
               pend_in = 1'b0;
               if (func_ff == FUNC_READ) state_in = ST_READ;
            end else if (accept) begin
               pend_in = 1'b1;
            end
         end
         ST_READ: begin
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(ABITS - 1)) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
         step_ff  <= step_in;
      end
   end

   // readout data path
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && pend_ff) begin
         hold_ff  <= ok_ff ? reg_rd_ff : REG_INIT;
         ehold_ff <= ok_ff ? edge_rd_ff : EDGE_INIT;
      end else if (state_ff == ST_READ) begin
         q0_ff <= mag(hold_ff.sum);
         q1_ff <= mag(ehold_ff.sum);
         n0_ff <= hold_ff.sum[SUM_BITS-1];
         n1_ff <= ehold_ff.sum[SUM_BITS-1];
         r0_ff <= '0;
         r1_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         q0_ff <= q0_in;
         q1_ff <= q1_in;
         r0_ff <= r0_in;
         r1_ff <= r1_in;
      end
   end

   // result transaction
   assign rsp_tvalid = (state_ff == ST_OUT);
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[7:0]     = region_ff;
      rsp_tdata[28:8]    = hold_ff.cnt;
      rsp_tdata[65:29]   = 37'($signed(hold_ff.sum));
      rsp_tdata[116:66]  = 51'(hold_ff.sq);
      rsp_tdata[132:117] = 16'($signed(hold_ff.mn));
      rsp_tdata[152:133] = 20'(hold_ff.mloc);
      rsp_tdata[168:153] = 16'($signed(hold_ff.mx));
      rsp_tdata[184:169] = 16'($signed(mean0));
      rsp_tdata[205:185] = ehold_ff.cnt;
      rsp_tdata[221:206] = 16'($signed(ehold_ff.mn));
      rsp_tdata[237:222] = 16'($signed(mean1));
      rsp_tdata[238]     = (hold_ff.cnt == '0);
      rsp_tdata[239]     = (ehold_ff.cnt == '0);
   end

endmodule

@@ hdl/rsa_checker.sv @@
// port-level checks for the region statistics accumulator
module rsa_checker
   import rsa_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [239:0] rsp_tdata
);

   // a pending result holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no input taken while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted during result");

   // empty region flag matches the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[238] == (rsp_tdata[28:8] == '0)))
      else $error("empty flag mismatch");

   // empty region reports zero mean
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[238] |-> rsp_tdata[184:169] == '0)
      else $error("empty mean not zero");

endmodule

bind region_statistics_accumulator_unit rsa_checker u_rsa_checker (.*);
